@@ rtl/bbal_pkg.sv @@
// shared types, constants and helpers of the buddy allocator
package bbal_pkg;

  localparam int LEVELS_DEF = 8;
  localparam int MIN_BLOCK_LOG2_DEF = 5;
  localparam int LW = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] NS_FREE  = 2'd0;
  localparam logic [1:0] NS_SPLIT = 2'd1;
  localparam logic [1:0] NS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_BAD_SIZE = 2'd1,
    STAT_NO_BLOCK = 2'd2,
    STAT_FREE_IGN = 2'd3
  } status_e;

  typedef struct packed {
    logic        op;
    logic [15:0] req_size;
    logic [15:0] offset;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] granted_offset;
    logic [12:0] block_bytes;
    logic [12:0] used_bytes;
  } rsp_t;

  typedef struct packed {
    logic [1:0] st;
    logic       hf;
  } node_t;

  localparam node_t NODE_RST = '{st: NS_FREE, hf: 1'b1};

  // smallest k with 2^k >= v, for v >= 1
  function automatic logic [4:0] ceil_log2_16(logic [15:0] v);
    logic [4:0] r;
    r = 5'd16;
    for (int k = 16; k >= 0; k--) begin
      if (17'(v) <= (17'd1 << k)) r = 5'(k);
    end
    return r;
  endfunction

endpackage

@@ rtl/bbal_req_if.sv @@
// request channel of the buddy allocator
interface bbal_req_if import bbal_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/bbal_rsp_if.sv @@
// response channel of the buddy allocator
interface bbal_rsp_if import bbal_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/bbal_vmem.sv @@
// single write, single read memory with per-entry valid bits and registered read
module bbal_vmem #(
  parameter int DW = 3,
  parameter int DEPTH = 255,
  parameter int AW = 8,
  parameter logic [DW-1:0] RST = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          wvalid_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  output logic          rvalid_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0] rdata_q;
  logic rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= wvalid_i;
      rvld_q <= vld_q[raddr_i];
    end
  end

  // an entry never written reads as its reset value
  assign rdata_o  = rvld_q ? rdata_q : RST;
  assign rvalid_o = rvld_q;

endmodule

@@ rtl/binary_buddy_allocator.sv @@
// steps from acceptance to a loaded result: a bad size goes straight to the result; an
// allocate reads and checks nodes, backtracks, splits down the right edge, takes the block and,
// if it split nothing, refreshes the flags up to the root; a free checks the record, then the
// node, then walks to the root merging buddies; one item at a time, ready again the cycle after
// the result loads
// reset clears control state and the node and record valid bits at once, no clearing pass
module binary_buddy_allocator import bbal_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF,
  parameter int MIN_BLOCK_LOG2 = MIN_BLOCK_LOG2_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  bbal_req_if.sink   req_i,
  bbal_rsp_if.source rsp_o
);

  localparam int POOL_LOG2 = MIN_BLOCK_LOG2 + LEVELS - 1;
  localparam int unsigned POOL_BYTES = 32'd1 << POOL_LOG2;
  localparam int NW = LEVELS;
  localparam int NODES = (1 << LEVELS) - 1;
  localparam int UW = (LEVELS > 1) ? LEVELS - 1 : 1;
  localparam int UNITS = 1 << (LEVELS - 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_A_RD   = 12'b000000000010,
    S_A_EV   = 12'b000000000100,
    S_A_BACK = 12'b000000001000,
    S_A_SPL  = 12'b000000010000,
    S_A_SPLL = 12'b000000100000,
    S_A_TAKE = 12'b000001000000,
    S_UP_RD  = 12'b000010000000,
    S_UP_EV  = 12'b000100000000,
    S_F_LEAF = 12'b001000000000,
    S_F_NODE = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } fsm_e;

  fsm_e state_q, state_d;
  logic [NW-1:0] cur_q, cur_d;       // node under the walker
  logic [LW-1:0] lvl_q, lvl_d;       // its level
  logic [LW-1:0] tgt_q, tgt_d;       // level of the block to allocate
  logic          op_q, op_d;
  logic [15:0]   off_q, off_d;
  logic          up_q, up_d;         // ancestors need a flag refresh after the take
  logic          flag_q, flag_d;     // has-free flag carried up the refresh walk
  logic          merge_q, merge_d;   // free walk still merging buddies
  logic [12:0]   used_q, used_d;
  rsp_t          res_q, res_d;
  rsp_t          rsp_q, rsp_d;
  logic          rsp_vq, rsp_vd;

  // node memory port
  logic          node_we;
  logic [NW-1:0] node_waddr, node_raddr;
  node_t         node_wdata, node_rd;
  logic [2:0]    node_rdata;

  // allocation record per smallest unit
  logic          leaf_we, leaf_wvalid, leaf_rvalid;
  logic [UW-1:0] leaf_waddr, leaf_raddr;
  logic [LW-1:0] leaf_rdata;

  bbal_vmem #(
    .DW(3), .DEPTH(NODES), .AW(NW), .RST(NODE_RST)
  ) u_node_mem (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata), .wvalid_i(1'b1),
    .raddr_i(node_raddr), .rdata_o(node_rdata), .rvalid_o()
  );

  bbal_vmem #(
    .DW(LW), .DEPTH(UNITS), .AW(UW), .RST('0)
  ) u_leaf_mem (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .we_i(leaf_we), .waddr_i(leaf_waddr), .wdata_i(tgt_q), .wvalid_i(leaf_wvalid),
    .raddr_i(leaf_raddr), .rdata_o(leaf_rdata), .rvalid_o(leaf_rvalid)
  );

  assign node_rd = node_t'(node_rdata);

  // record read issued while idle, so data is ready in the free check state
  assign leaf_raddr = UW'(32'(req_i.payload.offset) >> MIN_BLOCK_LOG2);

  // size of the node at the walker's level and its offset in the pool
  logic [4:0]  sh_cur;
  logic [31:0] blk_cur, pos_cur, gr_cur;
  assign sh_cur  = 5'(POOL_LOG2) - 5'(lvl_q);
  assign blk_cur = 32'd1 << sh_cur;
  assign pos_cur = 32'(cur_q) - ((32'd1 << lvl_q) - 32'd1);
  assign gr_cur  = pos_cur << sh_cur;

  // free checks on the recorded block
  logic [31:0] off32, blk_f, nidx_f;
  logic [4:0]  sh_f;
  logic        free_ok;
  assign off32  = 32'(off_q);
  assign sh_f   = 5'(POOL_LOG2) - 5'(leaf_rdata);
  assign blk_f  = 32'd1 << sh_f;
  assign nidx_f = ((32'd1 << leaf_rdata) - 32'd1) + (off32 >> sh_f);
  assign free_ok = (off32 < POOL_BYTES)
                && ((off32 & ((32'd1 << MIN_BLOCK_LOG2) - 32'd1)) == 32'd0)
                && leaf_rvalid
                && (32'(leaf_rdata) < 32'(LEVELS))
                && ((off32 & (blk_f - 32'd1)) == 32'd0);

  // size rounding for an allocate transaction
  logic [4:0] clog;
  logic [4:0] klog;
  logic       size_bad;
  assign clog = ceil_log2_16(req_i.payload.req_size);
  assign klog = (32'(clog) < 32'(MIN_BLOCK_LOG2)) ? 5'(MIN_BLOCK_LOG2) : clog;
  assign size_bad = (req_i.payload.req_size == 16'd0)
                 || (32'(req_i.payload.req_size) > POOL_BYTES);

  logic search_fail;
  assign search_fail = !node_rd.hf || (node_rd.st == NS_FULL)
                    || ((lvl_q == tgt_q) && (node_rd.st != NS_FREE));

  logic out_load;
  assign out_load = (state_q == S_FIN) && (!rsp_vq || rsp_o.ready);

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_vq;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    lvl_d   = lvl_q;
    tgt_d   = tgt_q;
    op_d    = op_q;
    off_d   = off_q;
    up_d    = up_q;
    flag_d  = flag_q;
    merge_d = merge_q;
    used_d  = used_q;
    res_d   = res_q;
    node_raddr  = cur_q;
    node_we     = 1'b0;
    node_waddr  = cur_q;
    node_wdata  = NODE_RST;
    leaf_we     = 1'b0;
    leaf_wvalid = 1'b0;
    leaf_waddr  = UW'(off32 >> MIN_BLOCK_LOG2);

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d  = req_i.payload.op;
          off_d = req_i.payload.offset;
          cur_d = '0;
          lvl_d = '0;
          tgt_d = LW'(POOL_LOG2 - int'(klog));
          res_d = '{status: STAT_DONE, granted_offset: '0, block_bytes: '0,
                    used_bytes: '0};
          if (req_i.payload.op == OP_FREE) begin
            state_d = S_F_LEAF;
          end else if (size_bad) begin
            res_d.status = STAT_BAD_SIZE;
            state_d = S_FIN;
          end else begin
            state_d = S_A_RD;
          end
        end
      end

      // depth-first search, right child first
      S_A_RD: begin
        node_raddr = cur_q;
        state_d = S_A_EV;
      end

      S_A_EV, S_A_BACK: begin
        if ((state_q == S_A_EV) && !search_fail) begin
          if (node_rd.st == NS_FREE) begin
            if (lvl_q == tgt_q) begin
              up_d = 1'b1;
              state_d = S_A_TAKE;
            end else begin
              up_d = 1'b0;
              state_d = S_A_SPL;
            end
          end else begin
            cur_d = (cur_q << 1) + NW'(2);
            lvl_d = lvl_q + LW'(1);
            state_d = S_A_RD;
          end
        end else begin
          // backtrack: right child falls to its left buddy, left child fails its parent
          if (cur_q == '0) begin
            res_d.status = STAT_NO_BLOCK;
            state_d = S_FIN;
          end else if (!cur_q[0]) begin
            cur_d = cur_q - NW'(1);
            state_d = S_A_RD;
          end else begin
            cur_d = cur_q >> 1;
            lvl_d = lvl_q - LW'(1);
            state_d = S_A_BACK;
          end
        end
      end

      // split free nodes down the right edge
      S_A_SPL: begin
        node_we    = 1'b1;
        node_waddr = cur_q;
        node_wdata = '{st: NS_SPLIT, hf: 1'b1};
        state_d = S_A_SPLL;
      end

      S_A_SPLL: begin
        node_we    = 1'b1;
        node_waddr = (cur_q << 1) + NW'(1);
        node_wdata = '{st: NS_FREE, hf: 1'b1};
        cur_d = (cur_q << 1) + NW'(2);
        lvl_d = lvl_q + LW'(1);
        state_d = ((lvl_q + LW'(1)) == tgt_q) ? S_A_TAKE : S_A_SPL;
      end

      S_A_TAKE: begin
        node_we    = 1'b1;
        node_waddr = cur_q;
        node_wdata = '{st: NS_FULL, hf: 1'b0};
        leaf_we     = 1'b1;
        leaf_wvalid = 1'b1;
        leaf_waddr  = UW'(gr_cur >> MIN_BLOCK_LOG2);
        res_d.status         = STAT_DONE;
        res_d.granted_offset = 12'(gr_cur);
        res_d.block_bytes    = 13'(blk_cur);
        used_d = used_q + 13'(blk_cur);
        flag_d = 1'b0;
        state_d = up_q ? S_UP_RD : S_FIN;
      end

      // walk to the root: read the buddy, then rewrite the parent
      S_UP_RD: begin
        if (cur_q == '0) begin
          state_d = S_FIN;
        end else begin
          node_raddr = cur_q[0] ? cur_q + NW'(1) : cur_q - NW'(1);
          cur_d = (cur_q - NW'(1)) >> 1;
          state_d = S_UP_EV;
        end
      end

      S_UP_EV: begin
        node_we    = 1'b1;
        node_waddr = cur_q;
        if (op_q == OP_ALLOC) begin
          node_wdata = '{st: NS_SPLIT, hf: node_rd.hf | flag_q};
          flag_d = node_rd.hf | flag_q;
        end else if (merge_q && (node_rd.st == NS_FREE)) begin
          node_wdata = '{st: NS_FREE, hf: 1'b1};
        end else begin
          node_wdata = '{st: NS_SPLIT, hf: 1'b1};
          merge_d = 1'b0;
        end
        state_d = S_UP_RD;
      end

      S_F_LEAF: begin
        if (free_ok) begin
          node_raddr = NW'(nidx_f);
          cur_d = NW'(nidx_f);
          lvl_d = leaf_rdata;
          state_d = S_F_NODE;
        end else begin
          res_d.status = STAT_FREE_IGN;
          state_d = S_FIN;
        end
      end

      S_F_NODE: begin
        if (node_rd.st == NS_FULL) begin
          node_we    = 1'b1;
          node_waddr = cur_q;
          node_wdata = '{st: NS_FREE, hf: 1'b1};
          leaf_we     = 1'b1;
          leaf_wvalid = 1'b0;
          res_d.block_bytes = 13'(blk_cur);
          used_d  = used_q - 13'(blk_cur);
          merge_d = 1'b1;
          state_d = S_UP_RD;
        end else begin
          res_d.status = STAT_FREE_IGN;
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // result slot, loaded only when empty or when the waiting result is taken in the same cycle
  always_comb begin
    rsp_d  = rsp_q;
    rsp_vd = rsp_vq;
    if (out_load) begin
      rsp_d = res_q;
      rsp_d.used_bytes = used_q;
      rsp_vd = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vd = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      rsp_vq  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      rsp_vq  <= rsp_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    lvl_q   <= lvl_d;
    tgt_q   <= tgt_d;
    op_q    <= op_d;
    off_q   <= off_d;
    up_q    <= up_d;
    flag_q  <= flag_d;
    merge_q <= merge_d;
    res_q   <= res_d;
    rsp_q   <= rsp_d;
  end

endmodule
